### rtl/aetp_pkg.sv
// Shared types, command codes and character constants for the ANSI escape parser.
package aetp_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST = 9'd80;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 9'd25;

    // Display action codes
    localparam logic [2:0] ACT_MOVE = 3'd0;
    localparam logic [2:0] ACT_PUT = 3'd1;
    localparam logic [2:0] ACT_NEWLINE = 3'd2;
    localparam logic [2:0] ACT_FG = 3'd3;
    localparam logic [2:0] ACT_BG = 3'd4;

    localparam logic [4:0] COLOUR_DEFAULT = 5'd16;

    // Command kinds passed from parser to emitter
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_MOVE = 3'd1;
    localparam logic [2:0] K_PUT = 3'd2;
    localparam logic [2:0] K_NEWLINE = 3'd3;
    localparam logic [2:0] K_MOVE_NL = 3'd4;
    localparam logic [2:0] K_FG = 3'd5;
    localparam logic [2:0] K_BG = 3'd6;
    localparam logic [2:0] K_RESET = 3'd7;

    // Result cap per byte
    localparam int unsigned OUT_LIMIT = 32;
    localparam int unsigned RUN_CNT_W = $clog2(OUT_LIMIT + 1);

    // Command queue geometry
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;

    // CSI argument range
    localparam int unsigned ARG_W = 16;
    localparam logic [ARG_W-1:0] ARG_SAT = 16'hFFFF;

    // Characters
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_UP = 8'h41;
    localparam logic [7:0] CH_DOWN = 8'h42;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_LEFT = 8'h44;
    localparam logic [7:0] CH_SGR = 8'h6D;
    localparam logic [7:0] CH_SAVE = 8'h73;
    localparam logic [7:0] CH_RESTORE = 8'h75;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } byte_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] target_col;
        logic [7:0] target_row;
        logic [7:0] glyph;
        logic [4:0] colour;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] glyph;
        logic [4:0] colour;
        logic       run_end;
    } cmd_t;

endpackage

### rtl/ansi_escape_terminal_parser.sv
// A result passes the command queue, then the emitter's command, hold and output registers.
// Throughput: one byte per cycle enters while the 2-entry command queue has room; the
//   emitter issues one result per step and closes a run with a separate run-end step.
// An SGR final byte holds the byte channel during the argument walk, longer on a full queue.
// Reset (rst_n low, async): parser to text mode, argument count and saved cursor cleared,
//   queue and output emptied, screen size back to 80 x 25; the argument store is not cleared.
module ansi_escape_terminal_parser #(
    parameter int MAX_ARGS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  aetp_pkg::byte_item_t               byte_data,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output aetp_pkg::out_item_t                cmd_data,
    input  logic                               cfg_wr_en,
    input  logic [aetp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aetp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [aetp_pkg::CFG_DATA_W-1:0] screen_width_reg;
    logic [aetp_pkg::CFG_DATA_W-1:0] screen_height_reg;

    logic            q_push, q_full, q_pop, q_valid;
    aetp_pkg::cmd_t  q_entry, q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg <= aetp_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= aetp_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                aetp_pkg::REG_SCREEN_WIDTH:  screen_width_reg <= cfg_data;
                aetp_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    aetp_front #(
        .MAX_ARGS (MAX_ARGS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_data     (byte_data),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    aetp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    aetp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

endmodule

### rtl/aetp_front.sv
// Parser front end: escape state machine, CSI argument store and SGR argument walk.
module aetp_front #(
    parameter int MAX_ARGS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 byte_valid,
    output logic                                 byte_ready,
    input  aetp_pkg::byte_item_t                 byte_data,
    input  logic [aetp_pkg::CFG_DATA_W-1:0]      screen_width,
    input  logic [aetp_pkg::CFG_DATA_W-1:0]      screen_height,
    input  logic                                 q_full,
    output logic                                 q_push,
    output aetp_pkg::cmd_t                       q_entry
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ARGS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ARGS - 1);

    localparam logic [2:0] ST_TEXT = 3'd0;
    localparam logic [2:0] ST_ESC = 3'd1;
    localparam logic [2:0] ST_CSI = 3'd2;
    localparam logic [2:0] ST_SGR_RD = 3'd3;
    localparam logic [2:0] ST_SGR_PUSH = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [aetp_pkg::ARG_W-1:0]   cur_reg, cur_next;
    logic [aetp_pkg::ARG_W-1:0]   first_reg, first_next;
    logic [7:0]                   saved_col_reg, saved_col_next;
    logic [7:0]                   saved_row_reg, saved_row_next;
    logic [IDX_W-1:0]             walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0]             walk_last_reg, walk_last_next;
    logic [aetp_pkg::ARG_W-1:0]   rd_data_reg;
    logic [aetp_pkg::ARG_W-1:0]   arg_mem [MAX_ARGS];
    logic                         mem_we;

    logic                         accept;
    logic [7:0]                   ch, x, y;
    logic                         is_digit, cnt_open, is_last;
    logic [19:0]                  cur_ext, cur_mul;
    logic [aetp_pkg::ARG_W-1:0]   cur_sat, n_raw, n;
    logic [8:0]                   w_last, h_last;
    logic [16:0]                  sum_x, sum_y, clamp_x, clamp_y;
    logic [7:0]                   row_up, row_dn, col_rt, col_lt, bs_col;
    logic [2:0]                   sgr_kind;
    logic [4:0]                   sgr_colour;
    logic [aetp_pkg::ARG_W-1:0]   d30, d40, d90, d100;

    assign ch = byte_data.text_byte;
    assign x = byte_data.cursor_col;
    assign y = byte_data.cursor_row;

    // Bytes are taken only in the parse states, with room for one command
    assign byte_ready = ((state_reg == ST_TEXT) || (state_reg == ST_ESC) ||
                         (state_reg == ST_CSI)) && !q_full;
    assign accept = byte_valid && byte_ready;

    // Decimal argument accumulation with saturation
    assign is_digit = (ch >= aetp_pkg::CH_ZERO) && (ch <= aetp_pkg::CH_NINE);
    assign cnt_open = cnt_reg < CNT_MAX;
    assign cur_ext = {4'b0, cur_reg};
    assign cur_mul = (cur_ext << 3) + (cur_ext << 1) + {16'b0, ch[3:0]};
    assign cur_sat = (cur_mul > 20'h0FFFF) ? aetp_pkg::ARG_SAT : cur_mul[15:0];

    // Move count, defaulting to one
    assign n_raw = (cnt_reg == '0) ? cur_reg : first_reg;
    assign n = (n_raw == '0) ? 16'd1 : n_raw;

    // Last valid column and row, a zero size counting as one
    assign w_last = (screen_width == 9'd0) ? 9'd0 : screen_width - 9'd1;
    assign h_last = (screen_height == 9'd0) ? 9'd0 : screen_height - 9'd1;

    // Cursor move targets
    assign sum_x = {9'b0, x} + {1'b0, n};
    assign sum_y = {9'b0, y} + {1'b0, n};
    assign clamp_x = (sum_x > {8'b0, w_last}) ? {8'b0, w_last} : sum_x;
    assign clamp_y = (sum_y > {8'b0, h_last}) ? {8'b0, h_last} : sum_y;
    assign col_rt = (clamp_x > 17'd255) ? 8'hFF : clamp_x[7:0];
    assign row_dn = (clamp_y > 17'd255) ? 8'hFF : clamp_y[7:0];
    assign row_up = (n >= {8'b0, y}) ? 8'd0 : y - n[7:0];
    assign col_lt = (n >= {8'b0, x}) ? 8'd0 : x - n[7:0];
    assign bs_col = (w_last > 9'd255) ? 8'hFF : w_last[7:0];

    // SGR argument classification
    assign d30 = rd_data_reg - 16'd30;
    assign d40 = rd_data_reg - 16'd40;
    assign d90 = rd_data_reg - 16'd90;
    assign d100 = rd_data_reg - 16'd100;

    always_comb
    begin
        sgr_kind = aetp_pkg::K_NONE;
        sgr_colour = 5'd0;
        if (rd_data_reg == 16'd0)
        begin
            sgr_kind = aetp_pkg::K_RESET;
            sgr_colour = aetp_pkg::COLOUR_DEFAULT;
        end
        else if (rd_data_reg >= 16'd30 && rd_data_reg <= 16'd37)
        begin
            sgr_kind = aetp_pkg::K_FG;
            sgr_colour = {2'b00, d30[2:0]};
        end
        else if (rd_data_reg == 16'd39)
        begin
            sgr_kind = aetp_pkg::K_FG;
            sgr_colour = aetp_pkg::COLOUR_DEFAULT;
        end
        else if (rd_data_reg >= 16'd40 && rd_data_reg <= 16'd47)
        begin
            sgr_kind = aetp_pkg::K_BG;
            sgr_colour = {2'b00, d40[2:0]};
        end
        else if (rd_data_reg == 16'd49)
        begin
            sgr_kind = aetp_pkg::K_BG;
            sgr_colour = aetp_pkg::COLOUR_DEFAULT;
        end
        else if (rd_data_reg >= 16'd90 && rd_data_reg <= 16'd97)
        begin
            sgr_kind = aetp_pkg::K_FG;
            sgr_colour = {2'b01, d90[2:0]};
        end
        else if (rd_data_reg >= 16'd100 && rd_data_reg <= 16'd107)
        begin
            sgr_kind = aetp_pkg::K_BG;
            sgr_colour = {2'b01, d100[2:0]};
        end
    end

    assign is_last = walk_idx_reg == walk_last_reg;

    // Parser state machine and command generation
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        first_next = first_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        walk_idx_next = walk_idx_reg;
        walk_last_next = walk_last_reg;
        mem_we = 1'b0;
        q_push = 1'b0;
        q_entry = '0;
        q_entry.run_end = 1'b1;

        unique case (state_reg)
            ST_TEXT:
            begin
                if (accept)
                begin
                    if (ch == aetp_pkg::CH_ESC)
                    begin
                        state_next = ST_ESC;
                    end
                    else
                    begin
                        unique case (ch)
                            aetp_pkg::CH_BS:
                            begin
                                if (x != 8'd0)
                                begin
                                    q_push = 1'b1;
                                    q_entry.kind = aetp_pkg::K_MOVE;
                                    q_entry.col = x - 8'd1;
                                    q_entry.row = y;
                                end
                                else if (y != 8'd0)
                                begin
                                    q_push = 1'b1;
                                    q_entry.kind = aetp_pkg::K_MOVE;
                                    q_entry.col = bs_col;
                                    q_entry.row = y - 8'd1;
                                end
                            end
                            aetp_pkg::CH_LF:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE_NL;
                                q_entry.row = y;
                            end
                            aetp_pkg::CH_CR:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_NEWLINE;
                            end
                            default:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_PUT;
                                q_entry.glyph = ch;
                            end
                        endcase
                    end
                end
            end
            ST_ESC:
            begin
                if (accept)
                begin
                    if (ch == aetp_pkg::CH_LBRACKET)
                    begin
                        state_next = ST_CSI;
                        cnt_next = '0;
                        cur_next = '0;
                    end
                    else
                    begin
                        state_next = ST_TEXT;
                    end
                end
            end
            ST_CSI:
            begin
                if (accept)
                begin
                    if (is_digit)
                    begin
                        if (cnt_open)
                        begin
                            cur_next = cur_sat;
                        end
                    end
                    else if (ch == aetp_pkg::CH_SEMI)
                    begin
                        if (cnt_open)
                        begin
                            mem_we = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                first_next = cur_reg;
                            end
                            cnt_next = cnt_reg + 1'b1;
                            cur_next = '0;
                        end
                    end
                    else
                    begin
                        // Final byte: close the argument in progress
                        mem_we = cnt_open;
                        cnt_next = '0;
                        state_next = ST_TEXT;
                        unique case (ch)
                            aetp_pkg::CH_UP:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE;
                                q_entry.col = x;
                                q_entry.row = row_up;
                            end
                            aetp_pkg::CH_DOWN:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE;
                                q_entry.col = x;
                                q_entry.row = row_dn;
                            end
                            aetp_pkg::CH_RIGHT:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE;
                                q_entry.col = col_rt;
                                q_entry.row = y;
                            end
                            aetp_pkg::CH_LEFT:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE;
                                q_entry.col = col_lt;
                                q_entry.row = y;
                            end
                            aetp_pkg::CH_SGR:
                            begin
                                state_next = ST_SGR_RD;
                                walk_idx_next = '0;
                                walk_last_next = cnt_open ? cnt_reg[IDX_W-1:0] : IDX_LAST;
                            end
                            aetp_pkg::CH_SAVE:
                            begin
                                saved_col_next = x;
                                saved_row_next = y;
                            end
                            aetp_pkg::CH_RESTORE:
                            begin
                                q_push = 1'b1;
                                q_entry.kind = aetp_pkg::K_MOVE;
                                q_entry.col = saved_col_reg;
                                q_entry.row = saved_row_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_SGR_RD:
            begin
                state_next = ST_SGR_PUSH;
            end
            ST_SGR_PUSH:
            begin
                // Skip silent arguments; the last one always closes the run
                if ((sgr_kind != aetp_pkg::K_NONE) || is_last)
                begin
                    if (!q_full)
                    begin
                        q_push = 1'b1;
                        q_entry.kind = sgr_kind;
                        q_entry.colour = sgr_colour;
                        q_entry.run_end = is_last;
                        state_next = is_last ? ST_TEXT : ST_SGR_RD;
                        walk_idx_next = walk_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_SGR_RD;
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_TEXT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TEXT;
            cnt_reg <= '0;
            saved_col_reg <= 8'd0;
            saved_row_reg <= 8'd0;
            walk_idx_reg <= '0;
            walk_last_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            walk_idx_reg <= walk_idx_next;
            walk_last_reg <= walk_last_next;
        end
    end

    // Argument accumulators
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        first_reg <= first_next;
    end

    // Argument store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            arg_mem[cnt_reg[IDX_W-1:0]] <= cur_reg;
        end
        rd_data_reg <= arg_mem[walk_idx_reg];
    end

endmodule

### rtl/aetp_queue.sv
// Short command queue between the parser front end and the result emitter.
module aetp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aetp_pkg::cmd_t push_entry,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output aetp_pkg::cmd_t head
);

    localparam logic [aetp_pkg::Q_PTR_W-1:0] PTR_LAST = aetp_pkg::Q_PTR_W'(aetp_pkg::Q_DEPTH - 1);
    localparam logic [aetp_pkg::Q_PTR_W:0] CNT_FULL = (aetp_pkg::Q_PTR_W + 1)'(aetp_pkg::Q_DEPTH);

    aetp_pkg::cmd_t                     slot_reg [aetp_pkg::Q_DEPTH];
    logic [aetp_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [aetp_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [aetp_pkg::Q_PTR_W:0]         cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign full = cnt_reg == CNT_FULL;
    assign valid = cnt_reg != '0;
    assign head = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/aetp_back.sv
// Result emitter: expands queued commands into display results and marks run ends.
module aetp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  aetp_pkg::cmd_t       q_head,
    output logic                 q_pop,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output aetp_pkg::out_item_t  cmd_data
);

    localparam logic [aetp_pkg::RUN_CNT_W-1:0] RUN_LIMIT =
        aetp_pkg::RUN_CNT_W'(aetp_pkg::OUT_LIMIT);

    logic                             cur_valid_reg, cur_valid_next;
    aetp_pkg::cmd_t                   cur_reg, cur_next;
    logic [1:0]                       step_reg, step_next;
    logic                             hold_valid_reg, hold_valid_next;
    aetp_pkg::out_item_t              hold_reg, hold_next;
    logic                             out_valid_reg, out_valid_next;
    aetp_pkg::out_item_t              out_reg, out_next;
    logic [aetp_pkg::RUN_CNT_W-1:0]   run_cnt_reg, run_cnt_next;

    logic [1:0]                       nres;
    aetp_pkg::out_item_t              res;
    logic                             out_free, slot_ok, keep, done;

    assign cmd_valid = out_valid_reg;
    assign cmd_data = out_reg;

    // Results per command kind
    always_comb
    begin
        unique case (cur_reg.kind)
            aetp_pkg::K_NONE:    nres = 2'd0;
            aetp_pkg::K_MOVE_NL: nres = 2'd2;
            aetp_pkg::K_RESET:   nres = 2'd2;
            default:             nres = 2'd1;
        endcase
    end

    // Result for the current step of the command
    always_comb
    begin
        res = '0;
        unique case (cur_reg.kind)
            aetp_pkg::K_MOVE:
            begin
                res.action = aetp_pkg::ACT_MOVE;
                res.target_col = cur_reg.col;
                res.target_row = cur_reg.row;
            end
            aetp_pkg::K_PUT:
            begin
                res.action = aetp_pkg::ACT_PUT;
                res.glyph = cur_reg.glyph;
            end
            aetp_pkg::K_NEWLINE:
            begin
                res.action = aetp_pkg::ACT_NEWLINE;
            end
            aetp_pkg::K_MOVE_NL:
            begin
                if (step_reg == 2'd0)
                begin
                    res.action = aetp_pkg::ACT_MOVE;
                    res.target_row = cur_reg.row;
                end
                else
                begin
                    res.action = aetp_pkg::ACT_NEWLINE;
                end
            end
            aetp_pkg::K_FG:
            begin
                res.action = aetp_pkg::ACT_FG;
                res.colour = cur_reg.colour;
            end
            aetp_pkg::K_BG:
            begin
                res.action = aetp_pkg::ACT_BG;
                res.colour = cur_reg.colour;
            end
            aetp_pkg::K_RESET:
            begin
                res.action = (step_reg == 2'd0) ? aetp_pkg::ACT_FG : aetp_pkg::ACT_BG;
                res.colour = aetp_pkg::COLOUR_DEFAULT;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !out_valid_reg || cmd_ready;
    assign slot_ok = !hold_valid_reg || out_free;
    assign keep = run_cnt_reg < RUN_LIMIT;

    // Newest result waits in the hold stage until the next one or the run end
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next = cur_reg;
        step_next = step_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        run_cnt_next = run_cnt_reg;
        done = 1'b0;

        if (out_valid_reg && cmd_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cur_valid_reg)
        begin
            if (step_reg < nres)
            begin
                if (slot_ok)
                begin
                    step_next = step_reg + 2'd1;
                    if (keep)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next = hold_reg;
                            out_next.last_of_run = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next = res;
                        hold_valid_next = 1'b1;
                        run_cnt_next = run_cnt_reg + 1'b1;
                    end
                end
            end
            else if (cur_reg.run_end)
            begin
                if (slot_ok)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next = hold_reg;
                        out_next.last_of_run = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    run_cnt_next = '0;
                    done = 1'b1;
                end
            end
            else
            begin
                done = 1'b1;
            end
        end

        // Take the next command as soon as the current one is finished
        q_pop = !cur_valid_reg || done;
        if (q_pop)
        begin
            cur_valid_next = q_valid;
            step_next = 2'd0;
            if (q_valid)
            begin
                cur_next = q_head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg <= 2'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            run_cnt_reg <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg <= step_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg <= out_valid_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        hold_reg <= hold_next;
        out_reg <= out_next;
    end

endmodule

### rtl/aetp_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
module aetp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input aetp_pkg::out_item_t cmd_data
);

    // A stalled result stays offered unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_data))
        else $error("result changed while stalled");

    // Only move results carry a target position
    a_move_fields: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd_data.action != aetp_pkg::ACT_MOVE) |->
        (cmd_data.target_col == 8'd0) && (cmd_data.target_row == 8'd0))
        else $error("target position on a non-move result");

    // Only put results carry a glyph
    a_glyph_field: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd_data.action != aetp_pkg::ACT_PUT) |-> (cmd_data.glyph == 8'd0))
        else $error("glyph on a non-put result");

    // Colour results stay within the palette, other results carry none
    a_colour_field: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |->
        (((cmd_data.action == aetp_pkg::ACT_FG) || (cmd_data.action == aetp_pkg::ACT_BG)) &&
         (cmd_data.colour <= aetp_pkg::COLOUR_DEFAULT)) ||
        (((cmd_data.action == aetp_pkg::ACT_MOVE) || (cmd_data.action == aetp_pkg::ACT_PUT) ||
          (cmd_data.action == aetp_pkg::ACT_NEWLINE)) && (cmd_data.colour == 5'd0)))
        else $error("bad action or colour on a result");

endmodule

bind ansi_escape_terminal_parser aetp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
);

### verif/tb_ansi_escape_terminal_parser.sv
// Self-checking testbench for the ANSI escape terminal parser.
`timescale 1ns / 1ps

module tb_ansi_escape_terminal_parser;

    localparam int unsigned ARG_SLOTS = 16;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned ITEMS_PER_PHASE = 28;

    // SGR parameter values
    localparam int unsigned SGR_RESET = 0;
    localparam int unsigned SGR_FG_LO = 30;
    localparam int unsigned SGR_FG_HI = 37;
    localparam int unsigned SGR_FG_DEFAULT = 39;
    localparam int unsigned SGR_BG_LO = 40;
    localparam int unsigned SGR_BG_HI = 47;
    localparam int unsigned SGR_BG_DEFAULT = 49;
    localparam int unsigned SGR_FG_BRIGHT_LO = 90;
    localparam int unsigned SGR_FG_BRIGHT_HI = 97;
    localparam int unsigned SGR_BG_BRIGHT_LO = 100;
    localparam int unsigned SGR_BG_BRIGHT_HI = 107;
    localparam int unsigned BRIGHT_OFFSET = 8;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_CSI
    } parse_mode_t;

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                byte_valid = 1'b0;
    logic                                byte_ready;
    aetp_pkg::byte_item_t                byte_data = '0;
    logic                                cmd_valid;
    logic                                cmd_ready = 1'b0;
    aetp_pkg::out_item_t                 cmd_data;
    logic                                cfg_wr_en = 1'b0;
    logic [aetp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [aetp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // Stimulus and scoreboard storage
    aetp_pkg::byte_item_t  pending_bytes[$];
    aetp_pkg::out_item_t   expected_cmds[$];
    aetp_pkg::out_item_t   run_cmds[$];
    int unsigned queued_bytes = 0;
    int unsigned mismatch_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    // Predictor state
    parse_mode_t mode_q = MODE_TEXT;
    logic [15:0] args_q[ARG_SLOTS];
    int unsigned arg_idx = 0;
    logic [7:0]  saved_col_q = '0;
    logic [7:0]  saved_row_q = '0;
    logic [8:0]  width_q = aetp_pkg::SCREEN_WIDTH_RST;
    logic [8:0]  height_q = aetp_pkg::SCREEN_HEIGHT_RST;

    ansi_escape_terminal_parser #(
        .MAX_ARGS(ARG_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data(byte_data),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_data(cmd_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Command predictor
    // ---------------------------------------------------------------
    function automatic int unsigned clamp_dim(input int unsigned v, input logic [8:0] size);
        int unsigned last;
        last = ((size == 0) ? 1 : int'(size)) - 1;
        return (v > last) ? last : v;
    endfunction

    function automatic void add_cmd(input logic [2:0] act, input logic [7:0] col,
                                    input logic [7:0] row, input logic [7:0] glyph,
                                    input logic [4:0] colour);
        aetp_pkg::out_item_t c;
        if (run_cmds.size() >= aetp_pkg::OUT_LIMIT)
            return;
        c.action = act;
        c.target_col = col;
        c.target_row = row;
        c.glyph = glyph;
        c.colour = colour;
        c.last_of_run = 1'b0;
        run_cmds.push_back(c);
    endfunction

    // Move targets saturate at 255
    function automatic void add_move(input int unsigned col, input int unsigned row);
        add_cmd(aetp_pkg::ACT_MOVE, (col > 255) ? 8'd255 : col[7:0],
                (row > 255) ? 8'd255 : row[7:0], 8'd0, 5'd0);
    endfunction

    function automatic void add_sgr(input int unsigned a);
        if (a == SGR_RESET)
        begin
            add_cmd(aetp_pkg::ACT_FG, 8'd0, 8'd0, 8'd0, aetp_pkg::COLOUR_DEFAULT);
            add_cmd(aetp_pkg::ACT_BG, 8'd0, 8'd0, 8'd0, aetp_pkg::COLOUR_DEFAULT);
        end
        else if (a >= SGR_FG_LO && a <= SGR_FG_HI)
            add_cmd(aetp_pkg::ACT_FG, 8'd0, 8'd0, 8'd0, 5'(a - SGR_FG_LO));
        else if (a == SGR_FG_DEFAULT)
            add_cmd(aetp_pkg::ACT_FG, 8'd0, 8'd0, 8'd0, aetp_pkg::COLOUR_DEFAULT);
        else if (a >= SGR_BG_LO && a <= SGR_BG_HI)
            add_cmd(aetp_pkg::ACT_BG, 8'd0, 8'd0, 8'd0, 5'(a - SGR_BG_LO));
        else if (a == SGR_BG_DEFAULT)
            add_cmd(aetp_pkg::ACT_BG, 8'd0, 8'd0, 8'd0, aetp_pkg::COLOUR_DEFAULT);
        else if (a >= SGR_FG_BRIGHT_LO && a <= SGR_FG_BRIGHT_HI)
            add_cmd(aetp_pkg::ACT_FG, 8'd0, 8'd0, 8'd0,
                    5'(a - SGR_FG_BRIGHT_LO + BRIGHT_OFFSET));
        else if (a >= SGR_BG_BRIGHT_LO && a <= SGR_BG_BRIGHT_HI)
            add_cmd(aetp_pkg::ACT_BG, 8'd0, 8'd0, 8'd0,
                    5'(a - SGR_BG_BRIGHT_LO + BRIGHT_OFFSET));
    endfunction

    function automatic string fmt_cmd(input aetp_pkg::out_item_t c);
        return $sformatf("act=%0d col=%0d row=%0d glyph=%02h colour=%0d last=%0b",
                         c.action, c.target_col, c.target_row, c.glyph, c.colour,
                         c.last_of_run);
    endfunction

    // Advance the parser by one byte and queue the commands it produces
    task automatic predict_cmds(input aetp_pkg::byte_item_t item);
        logic [7:0]  ch;
        logic [7:0]  x;
        logic [7:0]  y;
        int unsigned acc;
        int unsigned step;
        int unsigned slots;
        int unsigned k;
        ch = item.text_byte;
        x = item.cursor_col;
        y = item.cursor_row;
        run_cmds.delete();
        case (mode_q)
            MODE_ESC:
            begin
                if (ch == aetp_pkg::CH_LBRACKET)
                begin
                    mode_q = MODE_CSI;
                    arg_idx = 0;
                    args_q[0] = '0;
                end
                else
                    mode_q = MODE_TEXT;
            end
            MODE_CSI:
            begin
                if (ch >= aetp_pkg::CH_ZERO && ch <= aetp_pkg::CH_NINE)
                begin
                    // digits past the last slot are dropped
                    if (arg_idx < ARG_SLOTS)
                    begin
                        acc = int'(args_q[arg_idx]) * 10 + int'(ch - aetp_pkg::CH_ZERO);
                        args_q[arg_idx] = (acc > int'(aetp_pkg::ARG_SAT)) ?
                                          aetp_pkg::ARG_SAT : acc[15:0];
                    end
                end
                else if (ch == aetp_pkg::CH_SEMI)
                begin
                    if (arg_idx < ARG_SLOTS)
                    begin
                        arg_idx++;
                        if (arg_idx < ARG_SLOTS)
                            args_q[arg_idx] = '0;
                    end
                end
                else
                begin
                    // final byte
                    step = (args_q[0] == 0) ? 1 : int'(args_q[0]);
                    case (ch)
                        aetp_pkg::CH_UP:
                            add_move(x, y - ((step < y) ? step : y));
                        aetp_pkg::CH_DOWN:
                            add_move(x, clamp_dim(y + step, height_q));
                        aetp_pkg::CH_RIGHT:
                            add_move(clamp_dim(x + step, width_q), y);
                        aetp_pkg::CH_LEFT:
                            add_move(x - ((step < x) ? step : x), y);
                        aetp_pkg::CH_SGR:
                        begin
                            slots = (arg_idx + 1 > ARG_SLOTS) ? ARG_SLOTS : arg_idx + 1;
                            for (k = 0; k < slots; k++)
                                add_sgr(args_q[k]);
                        end
                        aetp_pkg::CH_SAVE:
                        begin
                            saved_col_q = x;
                            saved_row_q = y;
                        end
                        aetp_pkg::CH_RESTORE:
                            add_move(saved_col_q, saved_row_q);
                        default:    ;
                    endcase
                    arg_idx = 0;
                    mode_q = MODE_TEXT;
                end
            end
            default:
            begin
                if (ch == aetp_pkg::CH_ESC)
                    mode_q = MODE_ESC;
                else if (ch == aetp_pkg::CH_BS)
                begin
                    // at the left edge wrap to the last column of the row above
                    if (x != 0)
                        add_move(x - 1, y);
                    else if (y != 0)
                        add_move(clamp_dim(32'hFFFF, width_q), y - 1);
                end
                else if (ch == aetp_pkg::CH_LF)
                begin
                    add_move(0, y);
                    add_cmd(aetp_pkg::ACT_NEWLINE, 8'd0, 8'd0, 8'd0, 5'd0);
                end
                else if (ch == aetp_pkg::CH_CR)
                    add_cmd(aetp_pkg::ACT_NEWLINE, 8'd0, 8'd0, 8'd0, 5'd0);
                else
                    add_cmd(aetp_pkg::ACT_PUT, 8'd0, 8'd0, ch, 5'd0);
            end
        endcase
        if (run_cmds.size() > 0)
            run_cmds[run_cmds.size() - 1].last_of_run = 1'b1;
        foreach (run_cmds[i])
            expected_cmds.push_back(run_cmds[i]);
    endtask

    // ---------------------------------------------------------------
    // Byte driver: feeds pending_bytes, predicts on each transfer
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                predict_cmds(byte_data);
            if (!byte_valid || byte_ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    byte_data <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Command monitor: random backpressure, compare each transfer
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        aetp_pkg::out_item_t want;
        if (!rst_n)
            cmd_ready <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected command: expected none, actual %s",
                             $time, fmt_cmd(cmd_data));
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_data.action !== want.action
                        || cmd_data.target_col !== want.target_col
                        || cmd_data.target_row !== want.target_row
                        || cmd_data.glyph !== want.glyph
                        || cmd_data.colour !== want.colour
                        || cmd_data.last_of_run !== want.last_of_run)
                    begin
                        mismatch_count++;
                        $display("%0t: command mismatch: expected %s, actual %s",
                                 $time, fmt_cmd(want), fmt_cmd(cmd_data));
                    end
                end
            end
            cmd_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] ch, input logic [7:0] col, input logic [7:0] row);
        aetp_pkg::byte_item_t item;
        item.text_byte = ch;
        item.cursor_col = col;
        item.cursor_row = row;
        pending_bytes.push_back(item);
        queued_bytes++;
    endtask

    task automatic push_number(input int unsigned v, input logic [7:0] col,
                               input logic [7:0] row);
        string digits;
        int    i;
        digits = $sformatf("%0d", v);
        for (i = 0; i < digits.len(); i++)
            push_byte(digits[i], col, row);
    endtask

    task automatic push_csi_intro(input logic [7:0] col, input logic [7:0] row);
        push_byte(aetp_pkg::CH_ESC, col, row);
        push_byte(aetp_pkg::CH_LBRACKET, col, row);
    endtask

    // Wait until the block has nothing left to deliver, then let it settle
    task automatic wait_drain();
        @(negedge clk);
        while (pending_bytes.size() != 0 || byte_valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers written on consecutive edges while idle
    task automatic set_screen(input logic [8:0] w, input logic [8:0] h);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= aetp_pkg::REG_SCREEN_WIDTH;
        cfg_data <= w;
        width_q = w;
        @(posedge clk);
        cfg_index <= aetp_pkg::REG_SCREEN_HEIGHT;
        cfg_data <= h;
        height_q = h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly inside the screen, with edges and off-screen values mixed in
    function automatic logic [7:0] pick_coord(input logic [8:0] dim);
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(255));
            default: return 8'($urandom_range((dim == 0) ? 0 : int'(dim) - 1));
        endcase
    endfunction

    function automatic int unsigned pick_sgr_arg();
        case ($urandom_range(9))
            0:       return SGR_RESET;
            1:       return SGR_FG_LO + $urandom_range(7);
            2:       return ($urandom_range(1) != 0) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
            3:       return SGR_BG_LO + $urandom_range(7);
            4:       return SGR_FG_BRIGHT_LO + $urandom_range(7);
            5:       return SGR_BG_BRIGHT_LO + $urandom_range(7);
            6:       return $urandom_range(120);
            7:       return $urandom_range(999999, 65530);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // One random byte sequence: mostly well-formed CSI with random content
    task automatic queue_random_sequence();
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  ch;
        int unsigned n_args;
        int unsigned k;
        bit          all_zero;
        int unsigned v;
        col = pick_coord(width_q);
        row = pick_coord(height_q);
        case ($urandom_range(9))
            0, 1:
                push_byte(8'($urandom_range(255)), col, row);
            2:
            begin
                case ($urandom_range(2))
                    0:       ch = aetp_pkg::CH_BS;
                    1:       ch = aetp_pkg::CH_LF;
                    default: ch = aetp_pkg::CH_CR;
                endcase
                if ($urandom_range(2) == 0)
                    col = 8'd0;
                push_byte(ch, col, row);
            end
            3, 4:
            begin
                // cursor move with absent, zero, small, medium or saturating count
                push_csi_intro(col, row);
                case ($urandom_range(4))
                    0:       ;
                    1:       push_byte(aetp_pkg::CH_ZERO, col, row);
                    2:       push_number($urandom_range(9, 1), col, row);
                    3:       push_number($urandom_range(300), col, row);
                    default: push_number($urandom_range(9999999, 65530), col, row);
                endcase
                if ($urandom_range(4) == 0)
                begin
                    push_byte(aetp_pkg::CH_SEMI, col, row);
                    push_number($urandom_range(99), col, row);
                end
                push_byte(8'(aetp_pkg::CH_UP + $urandom_range(3)), col, row);
            end
            5:
            begin
                push_csi_intro(col, row);
                if ($urandom_range(3) == 0)
                    push_number($urandom_range(50), col, row);
                push_byte(($urandom_range(1) != 0) ? aetp_pkg::CH_SAVE : aetp_pkg::CH_RESTORE,
                          col, row);
            end
            6, 7:
            begin
                // SGR; long runs reach or exceed the argument store
                n_args = ($urandom_range(5) == 0) ? $urandom_range(20, 16) : $urandom_range(4, 1);
                all_zero = (n_args >= ARG_SLOTS) && ($urandom_range(1) != 0);
                push_csi_intro(col, row);
                for (k = 0; k < n_args; k++)
                begin
                    if (k > 0)
                        push_byte(aetp_pkg::CH_SEMI, col, row);
                    v = all_zero ? SGR_RESET : pick_sgr_arg();
                    if (v != SGR_RESET || $urandom_range(2) != 0)
                        push_number(v, col, row);
                end
                push_byte(aetp_pkg::CH_SGR, col, row);
            end
            8:
            begin
                // ESC followed by something other than the bracket
                ch = 8'($urandom_range(255));
                if (ch == aetp_pkg::CH_LBRACKET)
                    ch = aetp_pkg::CH_LBRACKET + 8'd1;
                push_byte(aetp_pkg::CH_ESC, col, row);
                push_byte(ch, col, row);
            end
            default:
            begin
                // CSI with random parameter bytes and an arbitrary final byte
                push_csi_intro(col, row);
                n_args = $urandom_range(6);
                for (k = 0; k < n_args; k++)
                begin
                    if ($urandom_range(3) == 0)
                        push_byte(aetp_pkg::CH_SEMI, col, row);
                    else
                        push_byte(8'(aetp_pkg::CH_ZERO + $urandom_range(9)), col, row);
                end
                ch = 8'($urandom_range(255));
                while ((ch >= aetp_pkg::CH_ZERO && ch <= aetp_pkg::CH_NINE) ||
                       ch == aetp_pkg::CH_SEMI)
                    ch = 8'($urandom_range(255));
                push_byte(ch, col, row);
            end
        endcase
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                    input int unsigned stall_pct, input logic [8:0] w,
                                    input logic [8:0] h, input bit pause_midway);
        int unsigned start;
        set_screen(w, h);
        @(negedge clk);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start = queued_bytes;
        while (queued_bytes - start < n_items)
        begin
            // hold the sender until everything so far has come out
            if (pause_midway && queued_bytes - start >= n_items / 2)
            begin
                wait_drain();
                @(negedge clk);
                pause_midway = 1'b0;
            end
            queue_random_sequence();
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        foreach (args_q[i])
            args_q[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset screen size, no idling
        push_byte("A", 8'd0, 8'd0);
        push_byte(8'hFF, 8'd255, 8'd255);
        push_byte(aetp_pkg::CH_BS, 8'd0, 8'd0);     // origin: nothing happens
        push_byte(aetp_pkg::CH_BS, 8'd0, 8'd7);     // wraps to row above
        push_byte(aetp_pkg::CH_BS, 8'd5, 8'd3);
        push_byte(aetp_pkg::CH_LF, 8'd12, 8'd4);
        push_byte(aetp_pkg::CH_CR, 8'd40, 8'd20);
        push_byte(aetp_pkg::CH_ESC, 8'd1, 8'd1);    // ESC not followed by bracket
        push_byte("Q", 8'd1, 8'd1);
        push_csi_intro(8'd9, 8'd9);                 // restore with nothing saved
        push_byte(aetp_pkg::CH_RESTORE, 8'd9, 8'd9);
        push_csi_intro(8'd3, 8'd0);                 // default count, top row
        push_byte(aetp_pkg::CH_UP, 8'd3, 8'd0);
        push_csi_intro(8'd75, 8'd1);                // clamps at right edge
        push_number(9, 8'd75, 8'd1);
        push_byte(aetp_pkg::CH_RIGHT, 8'd75, 8'd1);
        push_csi_intro(8'd0, 8'd0);                 // bare SGR resets both colours
        push_byte(aetp_pkg::CH_SGR, 8'd0, 8'd0);
        push_csi_intro(8'd2, 8'd2);                 // unsupported final byte
        push_byte("Z", 8'd2, 8'd2);
        wait_drain();

        run_random_phase(ITEMS_PER_PHASE, 0, 0, 9'd256, 9'd256, 1'b0);
        run_random_phase(ITEMS_PER_PHASE, 62, 0, 9'd1, 9'd1, 1'b1);
        run_random_phase(ITEMS_PER_PHASE, 0, 62, 9'($urandom_range(256, 1)),
                         9'($urandom_range(256, 1)), 1'b0);
        run_random_phase(ITEMS_PER_PHASE, 15, 15, 9'd256, 9'd1, 1'b0);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
